// ===== src/pls_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pls_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 7;
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 16;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_POS   = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_PUT,
    S_DOWN,
    S_SCAN,
    S_DONE
  } state_t;

  // stream payload layouts, lowest field in the lowest bits
  typedef struct packed {
    logic [0:0]                pad;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] value;
  } in_data_t;

  typedef struct packed {
    logic [0:0]       pad;
    logic             is_empty;
    logic [POS_W-1:0] count;
    logic [POS_W-1:0] found_position;
  } out_data_t;

  typedef struct packed {
    status_t          status;
    logic [POS_W-1:0] found_position;
    logic [POS_W-1:0] count;
    logic             is_empty;
  } res_t;

  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [VALUE_W-1:0] wdata;
    logic [ADDR_W-1:0]  raddr;
  } mem_req_t;

endpackage

`default_nettype wire

// ===== src/positional_list_store.sv =====
// Sequence: clear, a rejected command and an append or a delete of the last entry go
// straight to the result; insert at p moves the entries from p up, last first, then writes
// the value; delete at p moves the later entries down; find scans from the first entry on.
// Throughput: one command at a time, the next taken only once the last result has gone into
// the output register; moves and scans go one entry per cycle through the memory port.
// Reset: the length goes to zero and the output empties; the entry memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module positional_list_store (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // value [31:0], position [38:32], zero pad [39]
  input  wire logic [pls_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // cmd [1:0]
  input  wire logic [1:0]                         s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // found_position [6:0], count [13:7], is_empty [14], zero pad [15]
  output logic [pls_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
  // status [1:0]
  output logic [1:0]                              m_axis_tuser
);

  import pls_pkg::*;

  in_data_t  in_data;
  out_data_t out_data;
  res_t      seq_res;
  logic      seq_res_valid;
  logic      seq_res_ready;
  mem_req_t  mem_req;
  logic [VALUE_W-1:0] rdata;

  // output register: holds one finished result while the sequencer moves on
  res_t out_res;
  logic out_valid;

  assign in_data = in_data_t'(s_axis_tdata);

  pls_ram #(
    .DEPTH (CAPACITY),
    .DATA_W(VALUE_W)
  ) u_ram (
    .clk  (clk),
    .we   (mem_req.we),
    .waddr(mem_req.waddr),
    .wdata(mem_req.wdata),
    .raddr(mem_req.raddr),
    .rdata(rdata)
  );

  pls_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(s_axis_tvalid),
    .cmd_ready(s_axis_tready),
    .cmd      (cmd_t'(s_axis_tuser)),
    .value    (in_data.value),
    .position (in_data.position),
    .res_valid(seq_res_valid),
    .res_ready(seq_res_ready),
    .res      (seq_res),
    .mem_req  (mem_req),
    .rdata    (rdata)
  );

  // take a new result when the register is empty or is drained this cycle
  assign seq_res_ready = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (seq_res_ready) begin
      out_valid <= seq_res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_res_valid && seq_res_ready) begin
      out_res <= seq_res;
    end
  end

  always_comb begin
    out_data.pad            = '0;
    out_data.is_empty       = out_res.is_empty;
    out_data.count          = out_res.count;
    out_data.found_position = out_res.found_position;
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_res.status;

endmodule

`default_nettype wire

// ===== src/pls_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pls_ram #(
  parameter int DEPTH  = 64,
  parameter int DATA_W = 32,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/pls_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pls_seq (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cmd_valid,
  output logic                               cmd_ready,
  input  wire pls_pkg::cmd_t                 cmd,
  input  wire logic [pls_pkg::VALUE_W-1:0]   value,
  input  wire logic [pls_pkg::POS_W-1:0]     position,
  output logic                               res_valid,
  input  wire logic                          res_ready,
  output pls_pkg::res_t                      res,
  output pls_pkg::mem_req_t                  mem_req,
  input  wire logic [pls_pkg::VALUE_W-1:0]   rdata
);

  import pls_pkg::*;

  state_t             state, state_next;
  logic [CNT_W-1:0]   cnt, cnt_next;
  logic [ADDR_W-1:0]  idx, idx_next;
  logic [ADDR_W-1:0]  bound, bound_next;
  logic [VALUE_W-1:0] val, val_next;
  status_t            status, status_next;
  logic [POS_W-1:0]   where, where_next;

  logic [CMP_W-1:0] pos_c;
  logic [CMP_W-1:0] cnt_c;
  logic [ADDR_W-1:0] last_idx;
  logic [ADDR_W-1:0] pos_idx;

  assign pos_c    = CMP_W'(position);
  assign cnt_c    = CMP_W'(cnt);
  assign last_idx = ADDR_W'(cnt_c - CMP_W'(1));
  assign pos_idx  = ADDR_W'(pos_c - CMP_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    idx    <= idx_next;
    bound  <= bound_next;
    val    <= val_next;
    status <= status_next;
    where  <= where_next;
  end

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    idx_next      = idx;
    bound_next    = bound;
    val_next      = val;
    status_next   = status;
    where_next    = where;
    cmd_ready     = 1'b0;
    res_valid     = 1'b0;
    mem_req.we    = 1'b0;
    mem_req.waddr = idx;
    mem_req.wdata = rdata;
    mem_req.raddr = idx;

    case (state)
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          status_next = STAT_OK;
          where_next  = '0;
          state_next  = S_DONE;
          case (cmd)
            CMD_INSERT: begin
              if (pos_c == '0 || pos_c > cnt_c + CMP_W'(1)) begin
                status_next = STAT_BAD_POS;
              end else if (cnt_c >= CMP_W'(CAPACITY)) begin
                status_next = STAT_FULL;
              end else if (pos_c == cnt_c + CMP_W'(1)) begin
                // append: no tail to move
                mem_req.we    = 1'b1;
                mem_req.waddr = pos_idx;
                mem_req.wdata = value;
                cnt_next      = cnt + CNT_W'(1);
              end else begin
                // move the tail up, last entry first
                mem_req.raddr = last_idx;
                idx_next      = last_idx;
                bound_next    = pos_idx;
                val_next      = value;
                state_next    = S_UP;
              end
            end
            CMD_DELETE: begin
              if (pos_c == '0 || pos_c > cnt_c) begin
                status_next = STAT_BAD_POS;
              end else if (pos_c == cnt_c) begin
                cnt_next = cnt - CNT_W'(1);
              end else begin
                // move the tail down, first entry after the hole first
                mem_req.raddr = ADDR_W'(pos_c);
                idx_next      = ADDR_W'(pos_c);
                bound_next    = last_idx;
                state_next    = S_DOWN;
              end
            end
            CMD_FIND: begin
              if (cnt == '0) begin
                status_next = STAT_NOT_FOUND;
              end else begin
                mem_req.raddr = '0;
                idx_next      = '0;
                val_next      = value;
                state_next    = S_SCAN;
              end
            end
            default: begin
              cnt_next = '0;
            end
          endcase
        end
      end

      S_UP: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = idx + ADDR_W'(1);
        if (idx == bound) begin
          state_next = S_PUT;
        end else begin
          mem_req.raddr = idx - ADDR_W'(1);
          idx_next      = idx - ADDR_W'(1);
        end
      end

      S_PUT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = bound;
        mem_req.wdata = val;
        cnt_next      = cnt + CNT_W'(1);
        state_next    = S_DONE;
      end

      S_DOWN: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = idx - ADDR_W'(1);
        if (idx == bound) begin
          cnt_next   = cnt - CNT_W'(1);
          state_next = S_DONE;
        end else begin
          mem_req.raddr = idx + ADDR_W'(1);
          idx_next      = idx + ADDR_W'(1);
        end
      end

      S_SCAN: begin
        if (rdata == val) begin
          where_next = POS_W'(CNT_W'(idx) + CNT_W'(1));
          state_next = S_DONE;
        end else if (idx == last_idx) begin
          status_next = STAT_NOT_FOUND;
          state_next  = S_DONE;
        end else begin
          mem_req.raddr = idx + ADDR_W'(1);
          idx_next      = idx + ADDR_W'(1);
        end
      end

      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign res.status         = status;
  assign res.found_position = where;
  assign res.count          = POS_W'(cnt);
  assign res.is_empty       = (cnt == '0);

endmodule

`default_nettype wire

// ===== src/pls_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pls_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           s_axis_tvalid,
  input wire logic                           s_axis_tready,
  input wire logic [pls_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input wire logic [1:0]                     m_axis_tuser,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready
);

  import pls_pkg::*;

  out_data_t od;
  assign od = out_data_t'(m_axis_tdata);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a command is in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_where_only_ok: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != STAT_OK |-> od.found_position == '0)
    else $error("found position on a failed command");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> od.is_empty == (od.count == '0))
    else $error("empty flag disagrees with count");

endmodule

bind positional_list_store pls_checker u_pls_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready)
);

`default_nettype wire
